### rtl/sdtq_pkg.sv
package sdtq_pkg;

    localparam int unsigned TABLE_ENTRIES = 16;
    localparam int unsigned DIV_STEPS_PER_CYCLE = 4;

    typedef enum logic [1:0] {
        KIND_QUEUED = 2'd0,
        KIND_FIRED  = 2'd1,
        KIND_FULL   = 2'd2
    } kind_t;

    localparam logic ACTION_SCHEDULE = 1'b0;
    localparam logic ACTION_POLL     = 1'b1;

    typedef struct packed {
        logic        valid;
        logic [63:0] deadline;
        logic [7:0]  work;
        logic [31:0] arg;
    } entry_t;

    typedef struct packed {
        logic insert;
        logic pop;
    } cell_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_WAIT,
        ST_DECIDE,
        ST_OUT
    } state_t;

endpackage

### rtl/sorted_deadline_timer_queue.sv
// Sorted deadline timer queue built as a row of compare-and-shift cells.
// An item is taken only in the idle state; its first result beat is loaded after
// the scale step, the wait for the fire-time divider and the decide state. A new
// item is taken only once the last result beat of the previous one is gone.
// Reset (aresetn, synchronous, active low) empties all cells and sets
// cycles_per_usec to 1; no clearing pass is needed.
module sorted_deadline_timer_queue (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_action,
    input  logic [63:0] s_now_cycle,
    input  logic [39:0] s_deadline_usec,
    input  logic [7:0]  s_work_id,
    input  logic signed [31:0] s_work_arg,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_result_kind,
    output logic [7:0]  m_fired_work_id,
    output logic signed [31:0] m_fired_arg,
    output logic [63:0] m_fire_time_usec,
    output logic        m_last
);

    localparam int unsigned N = sdtq_pkg::TABLE_ENTRIES;

    sdtq_pkg::state_t state_reg, state_next;

    logic [15:0] cpu_reg;

    // Captured input beat.
    logic        action_reg;
    logic [63:0] now_reg;
    logic [39:0] dl_usec_reg;
    logic [7:0]  work_reg;
    logic [31:0] arg_reg;
    logic [63:0] dl_cyc_reg;

    // Result beat register.
    logic        m_valid_reg;
    logic [1:0]  kind_reg;
    logic [7:0]  out_work_reg;
    logic [31:0] out_arg_reg;
    logic [63:0] out_time_reg;
    logic        last_reg;

    logic        accept_in;
    logic        accept_out;
    logic        div_done;
    logic [63:0] div_quo;

    sdtq_pkg::cell_ctrl_t ctrl;
    sdtq_pkg::entry_t     new_entry;
    sdtq_pkg::entry_t     cell_ent   [N];
    sdtq_pkg::entry_t     left_ent   [N];
    sdtq_pkg::entry_t     right_ent  [N];
    logic                 cell_moves [N];
    logic                 left_moves [N];
    logic                 cell_due   [N];

    logic table_full;
    logic load_out;
    logic [1:0]  load_kind;
    logic [7:0]  load_work;
    logic [31:0] load_arg;
    logic [63:0] load_time;
    logic        load_last;

    assign accept_in  = s_valid && s_ready;
    assign accept_out = m_valid_reg && m_ready;
    assign table_full = cell_ent[N-1].valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cpu_reg <= 16'd1;
        end else if (cfg_wr_en) begin
            cpu_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept_in) begin
            action_reg  <= s_action;
            now_reg     <= s_now_cycle;
            dl_usec_reg <= s_deadline_usec;
            work_reg    <= s_work_id;
            arg_reg     <= s_work_arg;
        end
        if (state_reg == sdtq_pkg::ST_SCALE) begin
            // Product stays below 2^56; the raw register value is used here.
            dl_cyc_reg <= 64'(dl_usec_reg * cpu_reg);
        end
    end

    // The fire time is the same for every result of one beat, so the
    // divider starts as soon as the beat is taken.
    sdtq_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (accept_in),
        .dividend (s_now_cycle),
        .divisor  (cpu_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign new_entry = '{valid: 1'b1, deadline: dl_cyc_reg, work: work_reg, arg: arg_reg};

    // Cell 0 holds the earliest deadline; each cell talks only to its neighbors.
    for (genvar i = 0; i < N; i++) begin : g_cell
        if (i == 0) begin : g_first
            // A fixed valid entry that never moves sits left of cell 0, so
            // cell 0 takes a new entry that belongs at the front.
            assign left_ent[i]   = '{valid: 1'b1, default: '0};
            assign left_moves[i] = 1'b0;
        end else begin : g_mid
            assign left_ent[i]   = cell_ent[i-1];
            assign left_moves[i] = cell_moves[i-1];
        end
        if (i == N - 1) begin : g_last
            assign right_ent[i] = '0;
        end else begin : g_inner
            assign right_ent[i] = cell_ent[i+1];
        end
        sdtq_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .new_entry   (new_entry),
            .now_cycle   (now_reg),
            .left_entry  (left_ent[i]),
            .left_moves  (left_moves[i]),
            .right_entry (right_ent[i]),
            .entry       (cell_ent[i]),
            .moves       (cell_moves[i]),
            .due         (cell_due[i])
        );
    end

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sdtq_pkg::ST_IDLE: begin
                if (accept_in) begin
                    state_next = sdtq_pkg::ST_SCALE;
                end
            end
            sdtq_pkg::ST_SCALE: begin
                state_next = sdtq_pkg::ST_WAIT;
            end
            sdtq_pkg::ST_WAIT: begin
                if (div_done) begin
                    state_next = sdtq_pkg::ST_DECIDE;
                end
            end
            sdtq_pkg::ST_DECIDE: begin
                // A poll with nothing due ends without a result beat.
                if (action_reg == sdtq_pkg::ACTION_POLL && !cell_due[0]) begin
                    state_next = sdtq_pkg::ST_IDLE;
                end else begin
                    state_next = sdtq_pkg::ST_OUT;
                end
            end
            sdtq_pkg::ST_OUT: begin
                if (accept_out) begin
                    state_next = last_reg ? sdtq_pkg::ST_IDLE : sdtq_pkg::ST_DECIDE;
                end
            end
            default: begin
                state_next = sdtq_pkg::ST_IDLE;
            end
        endcase
    end

    // Output and cell-control logic.
    always_comb begin
        ctrl      = '0;
        load_out  = 1'b0;
        load_kind = sdtq_pkg::KIND_QUEUED;
        load_work = '0;
        load_arg  = '0;
        load_time = '0;
        load_last = 1'b1;
        case (state_reg)
            sdtq_pkg::ST_DECIDE: begin
                if (action_reg == sdtq_pkg::ACTION_POLL) begin
                    if (cell_due[0]) begin
                        // Pop the head; the next cell tells whether more follow.
                        load_out  = 1'b1;
                        ctrl.pop  = 1'b1;
                        load_kind = sdtq_pkg::KIND_FIRED;
                        load_work = cell_ent[0].work;
                        load_arg  = cell_ent[0].arg;
                        load_time = div_quo;
                        load_last = !cell_due[1];
                    end
                end else begin
                    load_out = 1'b1;
                    if (table_full) begin
                        load_kind = sdtq_pkg::KIND_FULL;
                    end else if (dl_cyc_reg <= now_reg) begin
                        load_kind = sdtq_pkg::KIND_FIRED;
                        load_work = work_reg;
                        load_arg  = arg_reg;
                        load_time = div_quo;
                    end else begin
                        ctrl.insert = 1'b1;
                    end
                end
            end
            default: begin
                ctrl = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sdtq_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (accept_out) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            kind_reg     <= load_kind;
            out_work_reg <= load_work;
            out_arg_reg  <= load_arg;
            out_time_reg <= load_time;
            last_reg     <= load_last;
        end
    end

    assign s_ready          = (state_reg == sdtq_pkg::ST_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_result_kind    = kind_reg;
    assign m_fired_work_id  = out_work_reg;
    assign m_fired_arg      = out_arg_reg;
    assign m_fire_time_usec = out_time_reg;
    assign m_last           = last_reg;

    // The block works on one beat at a time.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid_reg))
        else $error("input taken while a result beat is pending");

    // An insert must never push an entry off the end of the row.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.insert |-> !table_full)
        else $error("insert into a full table");

    // A pop only removes a due head entry.
    a_pop_due: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.pop |-> cell_due[0])
        else $error("pop of an entry that is not due");

    // A result beat is loaded only while the previous one is gone.
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |-> !m_valid_reg)
        else $error("result register overwritten");

endmodule

### rtl/sdtq_div.sv
module sdtq_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [15:0] divisor,
    output logic        done,
    output logic [63:0] quotient
);

    localparam int unsigned CNT_W = 5;
    localparam logic [CNT_W-1:0] CYCLES = CNT_W'(64 / sdtq_pkg::DIV_STEPS_PER_CYCLE);

    logic [63:0]      quo_reg, quo_next;
    logic [16:0]      rem_reg, rem_next;
    logic [15:0]      dsr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;

    // Restoring division, DIV_STEPS_PER_CYCLE quotient bits per cycle.
    always_comb begin
        logic [16:0] r;
        logic [63:0] q;
        r = rem_reg;
        q = quo_reg;
        for (int i = 0; i < int'(sdtq_pkg::DIV_STEPS_PER_CYCLE); i++) begin
            r = {r[15:0], q[63]};
            q = {q[62:0], 1'b0};
            if (r >= {1'b0, dsr_reg}) begin
                r = r - {1'b0, dsr_reg};
                q[0] = 1'b1;
            end
        end
        rem_next = r;
        quo_next = q;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
            quo_reg  <= dividend;
            rem_reg  <= '0;
            dsr_reg  <= (divisor == 16'd0) ? 16'd1 : divisor;
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CYCLES - 1'b1) begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign done     = !busy_reg && !start;
    assign quotient = quo_reg;

endmodule

### rtl/sdtq_cell.sv
module sdtq_cell (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  sdtq_pkg::cell_ctrl_t ctrl,
    input  sdtq_pkg::entry_t     new_entry,
    input  logic [63:0]          now_cycle,
    input  sdtq_pkg::entry_t     left_entry,
    input  logic                 left_moves,
    input  sdtq_pkg::entry_t     right_entry,
    output sdtq_pkg::entry_t     entry,
    output logic                 moves,
    output logic                 due
);

    sdtq_pkg::entry_t ent_reg;

    // Entries with a later deadline step right on insert; ties stay put.
    assign moves = ent_reg.valid && (ent_reg.deadline > new_entry.deadline);
    assign due   = ent_reg.valid && (ent_reg.deadline <= now_cycle);
    assign entry = ent_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ent_reg.valid <= 1'b0;
        end else if (ctrl.pop) begin
            ent_reg <= right_entry;
        end else if (ctrl.insert && (moves || !ent_reg.valid)) begin
            if (left_moves) begin
                ent_reg <= left_entry;
            end else if (left_entry.valid) begin
                // Only the cell right after the last staying entry takes the new one.
                ent_reg <= new_entry;
            end
        end
    end

endmodule

### tb/tb.sv
// Self-checking bench for the sorted deadline timer queue.
// A behavioral timer list in the class below predicts every result beat;
// stimulus and idling are randomized and checked in order.
class timer_list_board;
    bit          busy [16];
    bit [63:0]   deadline [16];
    bit [7:0]    work [16];
    bit [31:0]   argument [16];
    bit [3:0]    link [16];
    bit          has_link [16];
    bit          nonempty;
    bit [3:0]    head;
    bit [15:0]   scale;
    bit [106:0]  pending [$];
    int          errors;
    int          checked;

    function new();
        foreach (busy[i]) busy[i] = 0;
        nonempty = 0;
        head = 0;
        scale = 1;
        errors = 0;
        checked = 0;
    endfunction

    function bit [63:0] to_usec(bit [63:0] now);
        bit [63:0] d;
        d = (scale == 0) ? 64'd1 : {48'd0, scale};
        return now / d;
    endfunction

    function void push(sdtq_pkg::kind_t k, bit [7:0] id, bit [31:0] a, bit [63:0] t, bit l);
        pending.push_back({k, id, a, t, l});
    endfunction

    // Notes one accepted input beat and queues the results it causes.
    function void note_input(bit act, bit [63:0] now, bit [39:0] dl_us, bit [7:0] id,
                             bit [31:0] a);
        bit [63:0] dl;
        int slot;
        int n;
        bit [3:0] cur;
        bit [3:0] nxt;
        bit [106:0] e;
        slot = -1;
        if (act == sdtq_pkg::ACTION_SCHEDULE) begin
            dl = {24'd0, dl_us} * {48'd0, scale};
            for (int i = 0; i < 16; i++)
                if (!busy[i] && slot < 0) slot = i;
            if (slot < 0) begin
                push(sdtq_pkg::KIND_FULL, 8'd0, 32'd0, 64'd0, 1'b1);
            end else if (dl <= now) begin
                push(sdtq_pkg::KIND_FIRED, id, a, to_usec(now), 1'b1);
            end else begin
                busy[slot] = 1;
                deadline[slot] = dl;
                work[slot] = id;
                argument[slot] = a;
                has_link[slot] = 0;
                link[slot] = 0;
                if (!nonempty) begin
                    head = slot[3:0];
                    nonempty = 1;
                end else if (dl < deadline[head]) begin
                    link[slot] = head;
                    has_link[slot] = 1;
                    head = slot[3:0];
                end else begin
                    // Walk past every entry due no later than the new one.
                    cur = head;
                    while (has_link[cur]) begin
                        nxt = link[cur];
                        if (dl < deadline[nxt]) begin
                            link[slot] = nxt;
                            has_link[slot] = 1;
                            break;
                        end
                        cur = nxt;
                    end
                    link[cur] = slot[3:0];
                    has_link[cur] = 1;
                end
                push(sdtq_pkg::KIND_QUEUED, 8'd0, 32'd0, 64'd0, 1'b1);
            end
        end else begin
            n = 0;
            while (nonempty && n < 16 && deadline[head] <= now) begin
                push(sdtq_pkg::KIND_FIRED, work[head], argument[head], to_usec(now), 1'b0);
                n++;
                busy[head] = 0;
                if (has_link[head]) head = link[head];
                else begin
                    nonempty = 0;
                    head = 0;
                end
            end
            if (n > 0) begin
                e = pending.pop_back();
                e[0] = 1'b1;
                pending.push_back(e);
            end
        end
    endfunction

    function void check_result(bit [1:0] k, bit [7:0] id, bit [31:0] a, bit [63:0] t, bit l);
        bit [106:0] e;
        if (pending.size() == 0) begin
            $display("%0t: result beat with nothing expected, kind %0d", $time, k);
            errors++;
            return;
        end
        e = pending.pop_front();
        checked++;
        if (e[106:105] != k) begin
            $display("%0t: kind expected %0d actual %0d", $time, e[106:105], k);
            errors++;
        end
        if (e[104:97] != id) begin
            $display("%0t: work id expected %0d actual %0d", $time, e[104:97], id);
            errors++;
        end
        if (e[96:65] != a) begin
            $display("%0t: arg expected %h actual %h", $time, e[96:65], a);
            errors++;
        end
        if (e[64:1] != t) begin
            $display("%0t: fire time expected %0d actual %0d", $time, e[64:1], t);
            errors++;
        end
        if (e[0] != l) begin
            $display("%0t: last expected %0d actual %0d", $time, e[0], l);
            errors++;
        end
    endfunction
endclass

module tb;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_wr_en = 0;
    logic [15:0] cfg_wr_data = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic        s_action = 0;
    logic [63:0] s_now_cycle = 0;
    logic [39:0] s_deadline_usec = 0;
    logic [7:0]  s_work_id = 0;
    logic signed [31:0] s_work_arg = 0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [1:0]  m_result_kind;
    logic [7:0]  m_fired_work_id;
    logic signed [31:0] m_fired_arg;
    logic [63:0] m_fire_time_usec;
    logic        m_last;

    timer_list_board board;
    // Simulated time in cycles, advanced by the stimulus so that deadlines
    // sit in a sensible window around it.
    logic [63:0] clock_now;
    int          idle_cycles = 0;
    int          sched_count;
    int          poll_count;
    bit          sink_quiet;

    localparam int WATCHDOG_LIMIT = 20000;

    always #2 aclk = ~aclk;

    sorted_deadline_timer_queue uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_action(s_action),
        .s_now_cycle(s_now_cycle), .s_deadline_usec(s_deadline_usec),
        .s_work_id(s_work_id), .s_work_arg(s_work_arg),
        .m_valid(m_valid), .m_ready(m_ready), .m_result_kind(m_result_kind),
        .m_fired_work_id(m_fired_work_id), .m_fired_arg(m_fired_arg),
        .m_fire_time_usec(m_fire_time_usec), .m_last(m_last)
    );

    // The checker samples on the rising edge; a beat is taken on valid and ready.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_result(m_result_kind, m_fired_work_id, m_fired_arg,
                               m_fire_time_usec, m_last);
    end

    // The watchdog counts cycles in which neither channel moves a beat.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired after %0d quiet cycles", idle_cycles);
            $display("TB_ERROR");
            $finish;
        end
    end

    // The receiver stalls at random before taking each beat;
    // during quiet stretches it keeps ready high.
    initial begin : result_sink
        int gap;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            gap = sink_quiet ? 0 : $urandom_range(15);
            if (gap > 0) begin
                m_ready <= 0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    // Sends one beat after a random gap and waits until it is taken. Valid
    // goes low between beats.
    task automatic send_item(bit act, logic [63:0] now, logic [39:0] dl, logic [7:0] id,
                             logic [31:0] a, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(15);
        repeat (gap + 1) @(negedge aclk);
        s_valid <= 1;
        s_action <= act;
        s_now_cycle <= now;
        s_deadline_usec <= dl;
        s_work_id <= id;
        s_work_arg <= a;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_input(act, now, dl, id, a);
        if (act == sdtq_pkg::ACTION_SCHEDULE) sched_count++;
        else poll_count++;
        @(negedge aclk);
        s_valid <= 0;
    endtask

    // Waits for all expected beats, then lets the block settle past a poll
    // that may have caused nothing, before touching the register.
    task automatic drain();
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (40) @(negedge aclk);
    endtask

    task automatic write_scale(logic [15:0] v);
        drain();
        @(negedge aclk);
        cfg_wr_en <= 1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en <= 0;
        board.scale = v;
    endtask

    // A schedule whose deadline lies a random distance around the current time.
    task automatic random_schedule(bit quiet);
        logic [63:0] now;
        logic [39:0] dl;
        logic [63:0] base_us;
        logic [63:0] rnd;
        logic [31:0] id_rnd;
        logic [31:0] arg_rnd;
        int spread;
        base_us = board.to_usec(clock_now);
        rnd = {$urandom, $urandom};
        id_rnd = $urandom;
        arg_rnd = $urandom;
        spread = $urandom_range(3);
        case (spread)
            0: dl = base_us[39:0] + $urandom_range(40) - 10;
            1: dl = base_us[39:0] + $urandom_range(400);
            2: dl = base_us[39:0] + $urandom_range(5);
            default: dl = rnd[39:0];
        endcase
        if (board.scale > 16'd1000 && spread == 3) dl = dl & 40'h00_FFFF_FFFF;
        now = clock_now;
        send_item(sdtq_pkg::ACTION_SCHEDULE, now, dl, id_rnd[7:0], arg_rnd, quiet);
    endtask

    task automatic random_poll(bit quiet);
        logic [63:0] step;
        logic [31:0] r;
        logic [31:0] a;
        step = {48'd0, board.scale} * $urandom_range(60);
        clock_now = clock_now + step;
        r = $urandom;
        a = $urandom;
        send_item(sdtq_pkg::ACTION_POLL, clock_now, {8'd0, r}, r[7:0], a, quiet);
    endtask

    initial begin : stimulus
        logic [15:0] scales [5];
        int phase_items;
        board = new();
        sched_count = 0;
        poll_count = 0;
        sink_quiet = 0;
        clock_now = 64'd1000;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;

        // Directed part: immediate fires at the field extremes, a full table
        // with ties, one poll that hits the sixteen-beat cap, and empty polls.
        send_item(sdtq_pkg::ACTION_SCHEDULE, 64'hFFFF_FFFF_FFFF_FFFF, 40'hFF_FFFF_FFFF,
                  8'hFF, 32'h8000_0000, 0);
        send_item(sdtq_pkg::ACTION_SCHEDULE, 64'd0, 40'd0, 8'h00, 32'h7FFF_FFFF, 0);
        send_item(sdtq_pkg::ACTION_POLL, 64'd5, 40'd0, 8'd0, 32'd0, 0);
        for (int i = 0; i < 16; i++)
            send_item(sdtq_pkg::ACTION_SCHEDULE, 64'd10, 40'd100 + 40'(i % 3), i[7:0],
                      32'hFFFF_FFF0 + 32'(i), 0);
        send_item(sdtq_pkg::ACTION_SCHEDULE, 64'd10, 40'd50, 8'hAA, 32'h1234_5678, 0);
        send_item(sdtq_pkg::ACTION_POLL, 64'hFFFF_FFFF_FFFF_FFFF, 40'd0, 8'd0, 32'd0, 0);
        send_item(sdtq_pkg::ACTION_POLL, 64'd101, 40'd0, 8'd0, 32'd0, 0);

        // Random part across several scale settings, both extremes included.
        scales[0] = 16'd1;
        scales[1] = 16'hFFFF;
        scales[2] = 16'd0;
        scales[3] = 16'($urandom_range(2, 100));
        scales[4] = 16'($urandom_range(100, 65534));
        for (int p = 0; p < 5; p++) begin
            write_scale(scales[p]);
            clock_now = {16'd0, $urandom_range(1 << 20), 16'd0} | 64'd5;
            if (scales[p] == 16'hFFFF) clock_now = clock_now & 64'h0000_FFFF_FFFF_FFFF;
            phase_items = 90;
            for (int i = 0; i < phase_items; i++) begin
                // Every fourth run of twenty items goes without any gaps.
                sink_quiet = ((i / 20) % 4 == 3);
                if ($urandom_range(9) < 6) random_schedule(sink_quiet);
                else random_poll(sink_quiet);
            end
            sink_quiet = 0;
        end
        // Sweep the list clean so that its last entries are fired too.
        send_item(sdtq_pkg::ACTION_POLL, 64'hFFFF_FFFF_FFFF_FFFF, 40'd0, 8'd0, 32'd0, 0);
        send_item(sdtq_pkg::ACTION_POLL, 64'hFFFF_FFFF_FFFF_FFFF, 40'd0, 8'd0, 32'd0, 0);
        drain();

        $display("Sent %0d schedule and %0d poll beats over five scale settings.",
                 sched_count, poll_count);
        $display("Checked %0d result beats, %0d mismatches.", board.checked, board.errors);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

### files.f
rtl/sdtq_pkg.sv
rtl/sdtq_div.sv
rtl/sdtq_cell.sv
rtl/sorted_deadline_timer_queue.sv
tb/tb.sv
